// ===== rtl/lbp_pkg.sv =====
// Shared types and constants for the 3x3 local binary pattern stream.
// No dependencies; imported by lbp_linebuf and lbp_3x3_stream.
`default_nettype none

package lbp_pkg;

  localparam int PIX_W  = 8;
  localparam int CODE_W = 8;
  localparam int COORD_W = 10;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd256;
  localparam logic [CFG_W-1:0] SIZE_MIN   = 11'd3;

  // Per-word tag carried from the input stage to the compute stage.
  typedef struct packed {
    logic               emit;
    logic               frame_last;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
  } lbp_tag_t;

endpackage

`default_nettype wire

// ===== rtl/lbp_linebuf.sv =====
// Two line stores (upper and middle row) in synchronous RAM, registered read.
// Same-cycle write to the read address is forwarded. Uses lbp_pkg.
`default_nettype none

module lbp_linebuf #(
  parameter int DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  wire logic [lbp_pkg::PIX_W-1:0]   wr_upper,
  input  wire logic [lbp_pkg::PIX_W-1:0]   wr_middle,
  output logic      [lbp_pkg::PIX_W-1:0]   rd_upper,
  output logic      [lbp_pkg::PIX_W-1:0]   rd_middle
);
  import lbp_pkg::*;

  logic [PIX_W-1:0] upper_mem  [DEPTH];
  logic [PIX_W-1:0] middle_mem [DEPTH];
  logic [PIX_W-1:0] rd_upper_r;
  logic [PIX_W-1:0] rd_middle_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_upper_r  <= wr_upper;
        rd_middle_r <= wr_middle;
      end else begin
        rd_upper_r  <= upper_mem[rd_addr];
        rd_middle_r <= middle_mem[rd_addr];
      end
    end
  end

  assign rd_upper  = rd_upper_r;
  assign rd_middle = rd_middle_r;

endmodule

`default_nettype wire

// ===== rtl/lbp_3x3_stream.sv =====
// Top level: streaming 8-neighbour local binary pattern over a 3x3 window.
// Depends on lbp_pkg and lbp_linebuf.
//
// Takes one pixel word per clock unless stalled, and gives one code word per
// interior pixel after the pixel that completes its window, through the
// compute stage and output register. The line store RAM pair sets the rate:
// one read (at accept) and one write (compute stage) per cycle. Line stores
// are not cleared after reset. Any size write restarts the frame.
`default_nettype none

module lbp_3x3_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [lbp_pkg::PIX_W-1:0]         in_pixel,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [lbp_pkg::CODE_W-1:0]        out_lbp_code,
  output logic      [lbp_pkg::COORD_W-1:0]       out_center_row,
  output logic      [lbp_pkg::COORD_W-1:0]       out_center_col,
  output logic                                   out_frame_last,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lbp_pkg::CFG_W-1:0]         cfg_data
);
  import lbp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                             input int unsigned maxv);
    int unsigned r;
    r = 32'(v);
    if (v < SIZE_MIN) r = 32'(SIZE_MIN);
    else if (32'(v) > maxv) r = maxv;
    return r;
  endfunction

  // configuration and position
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // compute stage
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic [CW-1:0]    s1_col_r;
  lbp_tag_t         s1_tag_r;
  lbp_tag_t         tag_nxt;
  logic [PIX_W-1:0] win_r [6];

  // output register
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic [COORD_W-1:0] out_row_r;
  logic [COORD_W-1:0] out_col_r;
  logic              out_last_r;

  logic in_acc, adv, last_col, last_row;
  logic [31:0] row_m1, col_m1;
  logic [PIX_W-1:0] top, mid, ctr;
  logic [CODE_W-1:0] code;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign last_col = ((WW'(col_r) + WW'(1)) == width_r);
  assign last_row = ((HW'(row_r) + HW'(1)) == height_r);
  assign row_m1   = 32'(row_r) - 32'd1;
  assign col_m1   = 32'(col_r) - 32'd1;

  always_comb begin
    tag_nxt.emit       = (row_r >= RW'(2)) && (col_r >= CW'(2));
    tag_nxt.frame_last = last_col && last_row;
    tag_nxt.center_row = row_m1[COORD_W-1:0];
    tag_nxt.center_col = col_m1[COORD_W-1:0];
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(clamp_size(SIZE_RESET, MAX_WIDTH));
      height_r <= HW'(clamp_size(SIZE_RESET, MAX_HEIGHT));
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_wr_en &&
                 (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      if (cfg_index == REG_IMAGE_WIDTH) width_r <= WW'(clamp_size(cfg_data, MAX_WIDTH));
      else height_r <= HW'(clamp_size(cfg_data, MAX_HEIGHT));
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_pixel;
      s1_col_r   <= col_r;
      s1_tag_r   <= tag_nxt;
    end
  end

  lbp_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr   (col_r),
    .wr_en     (adv),
    .wr_addr   (s1_col_r),
    .wr_upper  (mid),
    .wr_middle (s1_pixel_r),
    .rd_upper  (top),
    .rd_middle (mid)
  );

  // window: [0..2] = column c-2 top/mid/bot, [3..5] = column c-1
  assign ctr = win_r[4];
  always_comb begin
    code[7] = win_r[0]   > ctr;
    code[6] = win_r[3]   > ctr;
    code[5] = top        > ctr;
    code[4] = mid        > ctr;
    code[3] = s1_pixel_r > ctr;
    code[2] = win_r[5]   > ctr;
    code[1] = win_r[2]   > ctr;
    code[0] = win_r[1]   > ctr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_pixel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_tag_r.emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_code_r <= code;
      out_row_r  <= s1_tag_r.center_row;
      out_col_r  <= s1_tag_r.center_col;
      out_last_r <= s1_tag_r.frame_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lbp_code   = out_code_r;
  assign out_center_row = out_row_r;
  assign out_center_col = out_col_r;
  assign out_frame_last = out_last_r;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < width_r)
    else $error("column counter beyond image width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    HW'(row_r) < height_r)
    else $error("row counter beyond image height");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted word lost before compute stage");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !adv)
    else $error("compute stage advanced over a stalled output word");

endmodule

`default_nettype wire

// ===== verif/lbp_checker.sv =====
// Checker for lbp_3x3_stream: watches the config port and both word channels,
// predicts each code word from its own line stores and window, and compares.
// Depends on lbp_pkg; instantiated by tb_top beside the block.
`default_nettype none

module lbp_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [lbp_pkg::PIX_W-1:0]     in_pixel,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [lbp_pkg::CODE_W-1:0]    out_lbp_code,
  input  wire logic [lbp_pkg::COORD_W-1:0]   out_center_row,
  input  wire logic [lbp_pkg::COORD_W-1:0]   out_center_col,
  input  wire logic                          out_frame_last,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbp_pkg::CFG_W-1:0]     cfg_data,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 codes_checked
);
  import lbp_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } lbp_word_t;

  lbp_word_t        code_q[$];
  logic [PIX_W-1:0] upper_line[MAX_WIDTH];
  logic [PIX_W-1:0] middle_line[MAX_WIDTH];
  logic [PIX_W-1:0] win[6];
  int unsigned      col_pos, row_pos, width, height;

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < SIZE_MIN) return 32'(SIZE_MIN);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  initial begin
    mismatches    = 0;
    pending       = 0;
    codes_checked = 0;
  end

  always @(posedge clk) begin : predict_and_compare
    logic [PIX_W-1:0] top, mid, ctr;
    lbp_word_t        want, got;
    if (!rst_n) begin
      code_q.delete();
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      width   = clamp_size(SIZE_RESET, MAX_WIDTH);
      height  = clamp_size(SIZE_RESET, MAX_HEIGHT);
    end else begin
      // outgoing word first so an unexpected word is never masked
      if (out_valid && !out_stall) begin
        got = '{out_lbp_code, out_center_row, out_center_col, out_frame_last};
        codes_checked++;
        if (code_q.size() == 0) begin
          if (mismatches < 10)
            $display("lbp_checker: unexpected word code %02h row %0d col %0d last %0b",
                     got.code, got.row, got.col, got.last);
          mismatches++;
        end else begin
          want = code_q.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("lbp_checker: mismatch expected code %02h row %0d col %0d last %0b",
                       want.code, want.row, want.col, want.last,
                       ", got code %02h row %0d col %0d last %0b",
                       got.code, got.row, got.col, got.last);
            mismatches++;
          end
        end
      end

      if (cfg_wr_en) begin
        if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
          if (cfg_index == REG_IMAGE_WIDTH) width = clamp_size(cfg_data, MAX_WIDTH);
          else height = clamp_size(cfg_data, MAX_HEIGHT);
          col_pos = 0;
          row_pos = 0;
        end
      end

      if (in_valid && !in_stall) begin
        top = upper_line[col_pos];
        mid = middle_line[col_pos];
        upper_line[col_pos]  = mid;
        middle_line[col_pos] = in_pixel;
        if (row_pos >= 2 && col_pos >= 2) begin
          ctr = win[4];
          want.code = {win[0] > ctr, win[3] > ctr, top > ctr, mid > ctr,
                       in_pixel > ctr, win[5] > ctr, win[2] > ctr, win[1] > ctr};
          want.row  = COORD_W'(row_pos - 1);
          want.col  = COORD_W'(col_pos - 1);
          want.last = (row_pos + 1 == height) && (col_pos + 1 == width);
          code_q.insert(code_q.size(), want);
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = in_pixel;
        col_pos++;
        if (col_pos >= width) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= height) row_pos = 0;
        end
      end
    end
    pending = code_q.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench top for lbp_3x3_stream: clock, reset, pixel stimulus, config
// writes, output stalls and the verdict. Depends on lbp_pkg and lbp_checker.
`default_nettype none

module tb_top;
  import lbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // three 3x3 frames in raster order; centre is the fifth word
  localparam logic [PIX_W-1:0] DIRECTED [27] = '{
    8'd129, 8'd128, 8'd127, 8'd127, 8'd128, 8'd255, 8'd200, 8'd128, 8'd0,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd254
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CODE_W-1:0]    out_lbp_code;
  logic [COORD_W-1:0]   out_center_row;
  logic [COORD_W-1:0]   out_center_col;
  logic                 out_frame_last;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int mismatches, pending, codes_checked;
  int pixels_sent = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lbp_3x3_stream dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_pixel,
    .out_valid, .out_stall, .out_lbp_code, .out_center_row, .out_center_col, .out_frame_last,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  lbp_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_pixel,
    .out_valid, .out_stall, .out_lbp_code, .out_center_row, .out_center_col, .out_frame_last,
    .cfg_wr_en, .cfg_index, .cfg_data,
    .mismatches, .pending, .codes_checked
  );

  always @(negedge clk) out_stall <= !quiet && ($urandom_range(0, 99) < 10);

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: watchdog expired with %0d words outstanding", pending);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] value);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  // random pixels, a quarter of them at one level so ties with the centre occur
  task automatic send_random(input int n);
    logic [PIX_W-1:0] level;
    level = PIX_W'($urandom_range(0, 255));
    repeat (n) send_pixel(($urandom_range(0, 3) == 0) ? level : PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  initial begin
    int w, h, n, random_pixels;
    random_pixels = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_pixel  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size 256x256: first row only, no codes yet
    send_random(40);

    // narrow width with the reset height: codes but no frame end
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 5);
    send_random(5 * 4);

    // sizes below the minimum clamp to 3x3
    set_size(0, 2);
    foreach (DIRECTED[i]) send_pixel(DIRECTED[i]);

    // spare register indexes mid-frame must not restart the frame
    send_random(4);
    wait_drained();
    write_reg(REG_SPARE_B, 2047);
    write_reg(REG_SPARE_A, 5);
    send_random(5);

    // width change mid-frame restarts at row 0
    set_size(5, 4);
    send_random(13);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 4);
    send_random(2 * 4 * 4);

    while (random_pixels < 380) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      set_size(w, h);
      n = $urandom_range(1, 3) * w * h;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > 380 - random_pixels) n = 380 - random_pixels;
      send_random(n);
      random_pixels += n;
    end

    // oversized height clamps, no idling on either side
    quiet = 1'b1;
    set_size(3, 2000);
    send_random(60);
    quiet = 1'b0;

    // oversized width clamps
    set_size(2047, 3);
    send_random(30);

    wait_drained();
    repeat (20) @(negedge clk);

    $display("tb_top: %0d pixels in, %0d codes out, %0d mismatching", pixels_sent,
             codes_checked, mismatches);
    $display("tb_top: covered reset size, clamped and restarted sizes, spare indexes,");
    $display("tb_top: random small frames and oversized width and height writes");
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
